[design/kbd_pkg.sv]
// ----------------------------------------------------------------------------
// kbd_pkg: scancode set 1 translation constants and tables
// Scancode values, table bounds, the plain and shifted maps, a fixed-key lookup.
// ----------------------------------------------------------------------------
package kbd_pkg;

	localparam int TABLE_LEN = 58;

	localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
	localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
	localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
	localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
	localparam logic [7:0] SC_CAPS_LO      = 8'h10;
	localparam logic [7:0] SC_CAPS_HI      = 8'h32;

	localparam logic [7:0] SC_ESCAPE = 8'h01;
	localparam logic [7:0] SC_LEFT   = 8'h4B;
	localparam logic [7:0] SC_RIGHT  = 8'h4D;
	localparam logic [7:0] SC_UP     = 8'h48;
	localparam logic [7:0] SC_DOWN   = 8'h50;
	localparam logic [7:0] SC_DELETE = 8'h53;
	localparam logic [7:0] SC_F1     = 8'h3B;
	localparam logic [7:0] SC_F2     = 8'h3C;

	localparam logic [6:0] PLAIN_MAP [0:TABLE_LEN-1] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
		7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
		7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
		7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
		7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
	};

	localparam logic [6:0] UPPER_MAP [0:TABLE_LEN-1] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
		7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
		7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
		7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
		7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
	};

	function automatic logic [6:0] fixed_key(input logic [7:0] code);
		logic [6:0] ch;
		case (code)
			SC_ESCAPE: ch = 7'h1B;
			SC_LEFT:   ch = 7'h3C;
			SC_RIGHT:  ch = 7'h3E;
			SC_UP:     ch = 7'h5E;
			SC_DOWN:   ch = 7'h76;
			SC_DELETE: ch = 7'h7F;
			SC_F1:     ch = 7'h46;
			SC_F2:     ch = 7'h47;
			default:   ch = 7'h00;
		endcase
		return ch;
	endfunction

endpackage

[design/keyboard_scancode_to_ascii.sv]
// A scancode beat moves to the input register, then to the result register.
// Throughput: one scancode per cycle; the input register and the result
// register each move every cycle unless the output side stalls.
// Reset: arst_n clears shift, caps lock and both valid flags at once.
// ----------------------------------------------------------------------------
// keyboard_scancode_to_ascii: set 1 scancode to ASCII translator
// Tracks shift and caps lock, maps make codes to characters, drops releases.
// ----------------------------------------------------------------------------
module keyboard_scancode_to_ascii import kbd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] scan_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] key_char
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       shift_q;
	logic       caps_q;
	logic       out_valid_q;
	logic [6:0] char_q;

	logic       advance;
	logic       load_s1;
	logic       shift_d;
	logic       caps_d;
	logic       hit;
	logic [6:0] ch;
	logic       upper;

	assign advance   = !out_valid_q || !out_stall;
	assign load_s1   = advance || !valid_s1;
	assign in_stall  = !load_s1;
	assign out_valid = out_valid_q;
	assign key_char  = char_q;

	always_comb begin
		shift_d = shift_q;
		caps_d  = caps_q;
		ch      = 7'h00;
		upper   = 1'b0;
		if (byte_s1 == SC_LSHIFT_MAKE || byte_s1 == SC_RSHIFT_MAKE) begin
			shift_d = 1'b1;
		end else if (byte_s1 == SC_LSHIFT_BREAK || byte_s1 == SC_RSHIFT_BREAK) begin
			shift_d = 1'b0;
		end else if (byte_s1 == SC_CAPS_MAKE) begin
			caps_d = !caps_q;
		end else if (!byte_s1[7]) begin
			ch = fixed_key(byte_s1);
			if (ch == 7'h00 && byte_s1 < 8'(TABLE_LEN)) begin
				upper = shift_q ||
					(caps_q && byte_s1 >= SC_CAPS_LO && byte_s1 <= SC_CAPS_HI);
				ch = upper ? UPPER_MAP[byte_s1[5:0]] : PLAIN_MAP[byte_s1[5:0]];
			end
		end
		hit = ch != 7'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			shift_q     <= 1'b0;
			caps_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				if (valid_s1) begin
					shift_q <= shift_d;
					caps_q  <= caps_d;
				end
				out_valid_q <= valid_s1 && hit;
			end
		end
	end

	// hold payload while stalled
	always_ff @(posedge clk) begin
		if (load_s1) begin
			byte_s1 <= scan_byte;
		end
		if (advance) begin
			char_q <= ch;
		end
	end

endmodule
